/* rtl/mpool_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpool_pkg
// Shared types, constants and the max-merge helper of the streaming max pool.
// ----------------------------------------------------------------------------
package mpool_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_KERNEL_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed sizes of the plane and of the register port.
  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W      = 10;
  localparam int OUT_IDX_W  = 10;
  localparam int HGT_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int STRIDE_W   = 4;

  // Merge form of a partial maximum: valid flag above a 32-bit signed value.
  localparam int VAL_W = 32;
  localparam int ACC_W = VAL_W + 1;

  typedef logic [ACC_W-1:0] acc_t;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_HEIGHT = 3'd0,
    REG_KERNEL_WIDTH  = 3'd1,
    REG_STRIDE_COLS   = 3'd2,
    REG_STRIDE_ROWS   = 3'd3,
    REG_PLANE_WIDTH   = 3'd4,
    REG_PLANE_HEIGHT  = 3'd5
  } cfg_reg_t;

  // Larger of two partial maxima; an entry without its valid flag never wins.
  function automatic acc_t max_merge(input acc_t a, input acc_t b);
    acc_t res;
    if (!a[VAL_W]) begin
      res = b;
    end else if (!b[VAL_W]) begin
      res = a;
    end else if ($signed(b[VAL_W-1:0]) > $signed(a[VAL_W-1:0])) begin
      res = b;
    end else begin
      res = a;
    end
    return res;
  endfunction

endpackage

/* rtl/mpool_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpool interfaces
// Valid/ready channels for samples, pooled results and register writes.
// ----------------------------------------------------------------------------
interface mpool_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          is_pad;
  modport source (output valid, sample, is_pad, input ready);
  modport sink   (input valid, sample, is_pad, output ready);
endinterface

interface mpool_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] max_value;
  logic [9:0]                    out_row;
  logic [9:0]                    out_col;
  logic                          end_of_plane;
  modport source (output valid, max_value, out_row, out_col, end_of_plane, input ready);
  modport sink   (input valid, max_value, out_row, out_col, end_of_plane, output ready);
endinterface

interface mpool_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/mpool_row_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpool_row_mem
// One row of the row store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mpool_row_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/mpool_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpool_cell
// One column cell of the horizontal chain: holds a column maximum, passes it
// to its neighbor on each shift and merges it into the running window maximum.
// ----------------------------------------------------------------------------
module mpool_cell
  import mpool_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 shift,
  input  logic                 in_window,
  input  logic [SAMPLE_BITS:0] d_in,
  output logic [SAMPLE_BITS:0] d_out,
  input  acc_t                 acc_in,
  output acc_t                 acc_out
);

  logic [SAMPLE_BITS:0] data_r;
  acc_t                 own;

  // Take the neighbor's column on each transfer through the chain.
  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= d_in;
    end
  end

  // Merge this column into the window maximum when it lies in the window.
  always_comb begin
    own     = {data_r[SAMPLE_BITS], VAL_W'($signed(data_r[SAMPLE_BITS-1:0]))};
    acc_out = in_window ? max_merge(acc_in, own) : acc_in;
  end

  assign d_out = data_r;

endmodule

/* rtl/max_pool_2d_stream_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2d_stream_top
// Streaming 2-D max pooling over padded feature planes.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one sample of the padded plane per transfer, in raster
//   order, with is_pad set on border positions; padding never wins a maximum
//   and a window of padding only gives the most negative value.
//   out_ch carries one result per completed window: its maximum, output row
//   and column, and end_of_plane on the last window of the plane.
//   cfg_ch writes kernel size, strides and plane size; it is always ready.
//   Every register write restarts the plane at row 0, column 0. Write only
//   while no sample is in flight.
// Throughput and pipeline:
//   One sample per cycle while out_ch does not stall. A result reaches out_ch
//   after the transfer of the sample that closes its window: the row store
//   is read at the transfer edge itself, then the column maximum goes into
//   the cell chain and the window maximum into the output register.
// Reset and stalls:
//   rst_n resets the registers to a 2x2 kernel, stride 2, 1024x1024 plane.
//   The row store needs no clearing. When out_ch stalls, the whole pipe
//   holds and in_ch.ready drops; the output register holds its result.
// ----------------------------------------------------------------------------
module max_pool_2d_stream_top
  import mpool_pkg::*;
#(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_KERNEL  = MAX_KERNEL_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  mpool_in_if.sink    in_ch,
  mpool_out_if.source out_ch,
  mpool_cfg_if.sink   cfg_ch
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int PWW = $clog2(MAX_WIDTH + 1);
  localparam int KW  = $clog2(MAX_KERNEL + 1);
  localparam int SW  = $clog2(MAX_KERNEL);
  localparam int EW  = SAMPLE_BITS + 1;

  // Configuration registers.
  logic [3:0]        kh_r, kw_r, sc_r, sr_r;
  logic [HGT_W-1:0]  pw_r, ph_r;
  logic              cfg_wr;

  // Clamped configuration.
  logic [KW-1:0]       kh_eff, kw_eff;
  logic [STRIDE_W-1:0] sc_eff, sr_eff;
  logic [PWW-1:0]      pw_eff;
  logic [HGT_W-1:0]    ph_eff;

  // Position counters.
  logic [CW-1:0]       c_r, c_nxt, ocol_r, ocol_nxt;
  logic [ROW_W-1:0]    r_r, r_nxt, orow_r, orow_nxt;
  logic [SW-1:0]       slot_r, slot_nxt;
  logic [STRIDE_W-1:0] cph_r, cph_nxt, rph_r, rph_nxt;

  logic en, accept;
  logic col_elig, row_elig, col_fire, row_fire, row_end, plane_end, last_win;

  // Pipeline stages.
  logic                 s1_valid_r, s2_valid_r, out_valid_r;
  logic [EW-1:0]        s1_entry_r;
  logic [SW-1:0]        s1_slot_r;
  logic                 s1_fire_r, s1_eop_r, s2_eop_r, out_eop_r;
  logic [OUT_IDX_W-1:0] s1_orow_r, s1_ocol_r, s2_orow_r, s2_ocol_r, out_row_r, out_col_r;
  logic [SAMPLE_BITS-1:0] out_val_r;

  logic [EW-1:0] rd     [MAX_KERNEL];
  logic [EW-1:0] col_max;
  logic [EW-1:0] chain_d [MAX_KERNEL+1];
  acc_t          chain_a [MAX_KERNEL+1];

  assign en     = !out_valid_r || out_ch.ready;
  assign accept = in_ch.valid && en;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr = cfg_ch.valid &&
                  (int'(cfg_ch.index) <= int'(REG_PLANE_HEIGHT));

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kh_r <= 4'd2;
      kw_r <= 4'd2;
      sc_r <= 4'd2;
      sr_r <= 4'd2;
      pw_r <= HGT_W'(1024);
      ph_r <= HGT_W'(1024);
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_KERNEL_HEIGHT: kh_r <= cfg_ch.data[3:0];
        REG_KERNEL_WIDTH:  kw_r <= cfg_ch.data[3:0];
        REG_STRIDE_COLS:   sc_r <= cfg_ch.data[3:0];
        REG_STRIDE_ROWS:   sr_r <= cfg_ch.data[3:0];
        REG_PLANE_WIDTH:   pw_r <= cfg_ch.data;
        REG_PLANE_HEIGHT:  ph_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Clamp register values to their working ranges.
  always_comb begin
    if (kh_r == '0)                       kh_eff = KW'(1);
    else if (int'(kh_r) > MAX_KERNEL)     kh_eff = KW'(MAX_KERNEL);
    else                                  kh_eff = KW'(kh_r);
    if (kw_r == '0)                       kw_eff = KW'(1);
    else if (int'(kw_r) > MAX_KERNEL)     kw_eff = KW'(MAX_KERNEL);
    else                                  kw_eff = KW'(kw_r);
    sc_eff = (sc_r == '0) ? STRIDE_W'(1) : sc_r;
    sr_eff = (sr_r == '0) ? STRIDE_W'(1) : sr_r;
    if (pw_r == '0)                       pw_eff = PWW'(1);
    else if (int'(pw_r) > MAX_WIDTH)      pw_eff = PWW'(MAX_WIDTH);
    else                                  pw_eff = PWW'(pw_r);
    if (ph_r == '0)                       ph_eff = HGT_W'(1);
    else if (int'(ph_r) > MAX_HEIGHT)     ph_eff = HGT_W'(MAX_HEIGHT);
    else                                  ph_eff = ph_r;
  end

  // Window detection and counter update for the sample in transfer.
  always_comb begin
    col_elig  = int'(c_r) + 1 >= int'(kw_eff);
    row_elig  = int'(r_r) + 1 >= int'(kh_eff);
    col_fire  = col_elig && (cph_r == '0);
    row_fire  = row_elig && (rph_r == '0);
    last_win  = (int'(r_r) + int'(sr_eff) >= int'(ph_eff)) &&
                (int'(c_r) + int'(sc_eff) >= int'(pw_eff));
    row_end   = int'(c_r) + 1 >= int'(pw_eff);
    plane_end = row_end && (int'(r_r) + 1 >= int'(ph_eff));

    c_nxt    = c_r + CW'(1);
    cph_nxt  = cph_r;
    ocol_nxt = ocol_r;
    r_nxt    = r_r;
    slot_nxt = slot_r;
    rph_nxt  = rph_r;
    orow_nxt = orow_r;
    if (col_elig) begin
      cph_nxt  = (cph_r + STRIDE_W'(1) == sc_eff) ? '0 : cph_r + STRIDE_W'(1);
      ocol_nxt = ocol_r + CW'(col_fire);
    end
    if (row_end) begin
      c_nxt    = '0;
      cph_nxt  = '0;
      ocol_nxt = '0;
      if (plane_end) begin
        r_nxt    = '0;
        slot_nxt = '0;
        rph_nxt  = '0;
        orow_nxt = '0;
      end else begin
        r_nxt    = r_r + ROW_W'(1);
        slot_nxt = (int'(slot_r) == MAX_KERNEL - 1) ? '0 : slot_r + SW'(1);
        if (row_elig) begin
          rph_nxt  = (rph_r + STRIDE_W'(1) == sr_eff) ? '0 : rph_r + STRIDE_W'(1);
          orow_nxt = orow_r + ROW_W'(row_fire);
        end
      end
    end
  end

  // Position counters; a register write restarts the plane.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      c_r    <= '0;
      r_r    <= '0;
      slot_r <= '0;
      cph_r  <= '0;
      rph_r  <= '0;
      ocol_r <= '0;
      orow_r <= '0;
    end else if (accept) begin
      c_r    <= c_nxt;
      r_r    <= r_nxt;
      slot_r <= slot_nxt;
      cph_r  <= cph_nxt;
      rph_r  <= rph_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
    end
  end

  // Row store: one memory per row slot, all read at the current column.
  for (genvar k = 0; k < MAX_KERNEL; k++) begin : g_row
    mpool_row_mem #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (EW)
    ) u_mem (
      .clk   (clk),
      .we    (accept && (slot_r == SW'(k))),
      .waddr (c_r),
      .wdata ({!in_ch.is_pad, in_ch.sample}),
      .re    (en),
      .raddr (c_r),
      .rdata (rd[k])
    );
  end

  // Stage 1: the sample beside the rows above it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_entry_r <= {!in_ch.is_pad, in_ch.sample};
      s1_slot_r  <= slot_r;
      s1_fire_r  <= col_fire && row_fire;
      s1_eop_r   <= last_win;
      s1_orow_r  <= OUT_IDX_W'(orow_r);
      s1_ocol_r  <= OUT_IDX_W'(ocol_r);
    end
  end

  // Column maximum over the kernel rows that end at this row.
  always_comb begin
    int            si;
    logic [EW-1:0] pick;
    acc_t          acc;
    acc = '0;
    for (int i = 0; i < MAX_KERNEL; i++) begin
      si = int'(s1_slot_r) - i;
      if (si < 0) begin
        si = si + MAX_KERNEL;
      end
      pick = (i == 0) ? s1_entry_r : rd[si[SW-1:0]];
      if (i < int'(kh_eff)) begin
        acc = max_merge(acc, {pick[SAMPLE_BITS],
                              VAL_W'($signed(pick[SAMPLE_BITS-1:0]))});
      end
    end
    col_max = {acc[VAL_W], acc[SAMPLE_BITS-1:0]};
  end

  // Stage 2: chain of column cells, newest column in cell 0.
  assign chain_d[0] = col_max;
  assign chain_a[0] = '0;
  for (genvar k = 0; k < MAX_KERNEL; k++) begin : g_cell
    mpool_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk       (clk),
      .shift     (en && s1_valid_r),
      .in_window (k < int'(kw_eff)),
      .d_in      (chain_d[k]),
      .d_out     (chain_d[k+1]),
      .acc_in    (chain_a[k]),
      .acc_out   (chain_a[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r && s1_fire_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_eop_r  <= s1_eop_r;
      s2_orow_r <= s1_orow_r;
      s2_ocol_r <= s1_ocol_r;
    end
  end

  // Output register: window maximum, most negative value if all padding.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val_r <= chain_a[MAX_KERNEL][VAL_W] ? chain_a[MAX_KERNEL][SAMPLE_BITS-1:0]
                                              : {1'b1, (SAMPLE_BITS-1)'(0)};
      out_row_r <= s2_orow_r;
      out_col_r <= s2_ocol_r;
      out_eop_r <= s2_eop_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.max_value    = out_val_r;
  assign out_ch.out_row      = out_row_r;
  assign out_ch.out_col      = out_col_r;
  assign out_ch.end_of_plane = out_eop_r;

endmodule

/* tb/sv/max_pool_2d_stream_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_2d_stream_top_tb
// Self-checking bench for the streaming 2-D max pool. Samples of padded
// planes are streamed in raster order while an in-bench window predictor
// computes each expected pooled result. Pooled results are compared field by
// field in arrival order. Both channels idle at random, and the register
// settings cover the extremes, out-of-range values and plane restarts.
// ----------------------------------------------------------------------------
module max_pool_2d_stream_top_tb
  import mpool_pkg::*;
;

  localparam int KMAX      = 8;
  localparam int WMAX      = 1024;
  localparam int LIMIT     = 600000;
  localparam int SETTLE    = 10;
  localparam int RAND_ITEMS = 900;

  typedef struct packed {
    logic signed [15:0] max_value;
    logic [9:0]         out_row;
    logic [9:0]         out_col;
    logic               end_of_plane;
  } pooled_t;

  logic clk;
  logic rst_n;

  mpool_in_if  #(.SAMPLE_BITS(16)) in_if ();
  mpool_out_if #(.SAMPLE_BITS(16)) out_if ();
  mpool_cfg_if                     cfg_if ();

  max_pool_2d_stream_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Shadow registers, counters and row store of the window predictor.
  logic [3:0]  win_h, win_w, step_c, step_r;
  logic [10:0] span_w, span_h;
  int          cur_row, cur_col;
  logic [16:0] line_buf [0:KMAX-1][0:WMAX-1];

  pooled_t pending_pools [$];
  int      mismatches;
  int      cycle_count;
  int      sent_items;
  bit      no_gaps;

  // Clock and cycle limit.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** max_pool_2d_stream_top: FAILED **");
      $finish;
    end
  end

  function automatic int clamp_to(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Register update of the predictor; listed writes restart the plane.
  task automatic shadow_write(logic [2:0] idx, logic [10:0] val);
    case (idx)
      REG_KERNEL_HEIGHT: win_h  = val[3:0];
      REG_KERNEL_WIDTH:  win_w  = val[3:0];
      REG_STRIDE_COLS:   step_c = val[3:0];
      REG_STRIDE_ROWS:   step_r = val[3:0];
      REG_PLANE_WIDTH:   span_w = val;
      REG_PLANE_HEIGHT:  span_h = val;
      default:           return;
    endcase
    cur_row = 0;
    cur_col = 0;
  endtask

  // Stores one sample and, when it closes a window, queues the pooled result.
  task automatic pool_sample(logic signed [15:0] s, logic pad);
    int kh, kw, sc, sr, pw, ph, r, c, orow, ocol, rr;
    bit found;
    logic signed [15:0] best;
    logic [16:0] e;
    pooled_t res;
    kh = clamp_to(win_h, KMAX);
    kw = clamp_to(win_w, KMAX);
    sc = clamp_to(step_c, 15);
    sr = clamp_to(step_r, 15);
    pw = clamp_to(span_w, WMAX);
    ph = clamp_to(span_h, 1024);
    r = cur_row;
    c = cur_col;
    if (r >= ph || c >= pw) begin
      r = 0;
      c = 0;
    end
    line_buf[r % KMAX][c] = {~pad, s};
    if (r + 1 >= kh && c + 1 >= kw && (r + 1 - kh) % sr == 0 && (c + 1 - kw) % sc == 0) begin
      orow = (r + 1 - kh) / sr;
      ocol = (c + 1 - kw) / sc;
      found = 0;
      best = 16'sh8000;
      for (int i = 0; i < kh; i++) begin
        rr = (r + 1 - kh + i) % KMAX;
        for (int j = 0; j < kw; j++) begin
          e = line_buf[rr][c + 1 - kw + j];
          if (e[16] && (!found || $signed(e[15:0]) > best)) begin
            best = e[15:0];
            found = 1;
          end
        end
      end
      res.max_value    = best;
      res.out_row      = orow[9:0];
      res.out_col      = ocol[9:0];
      res.end_of_plane = (orow == (ph - kh) / sr) && (ocol == (pw - kw) / sc);
      pending_pools.push_back(res);
    end
    c++;
    if (c >= pw) begin
      c = 0;
      r++;
      if (r >= ph) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endtask

  // Sends one sample; valid stays high when the next transfer follows at once.
  task automatic send_sample(logic signed [15:0] s, logic pad);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    in_if.is_pad <= pad;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    pool_sample(s, pad);
    sent_items++;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom());
    endcase
  endfunction

  // Waits for every pooled result, then for the pipeline to drain.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_pools.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [10:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    shadow_write(idx, val);
  endtask

  // Writes all six registers back to back while the block is idle.
  task automatic setup(int kh, int kw, int sc, int sr, int pw, int ph);
    wait_idle();
    cfg_write(REG_KERNEL_HEIGHT, 11'(kh));
    cfg_write(REG_KERNEL_WIDTH, 11'(kw));
    cfg_write(REG_STRIDE_COLS, 11'(sc));
    cfg_write(REG_STRIDE_ROWS, 11'(sr));
    cfg_write(REG_PLANE_WIDTH, 11'(pw));
    cfg_write(REG_PLANE_HEIGHT, 11'(ph));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_plane(int n, int pad_pct);
    for (int i = 0; i < n; i++) begin
      send_sample(rand_sample(), $urandom_range(0, 99) < pad_pct);
    end
  endtask

  // Result side: random stalls, with stretches of steady acceptance.
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // Compares each result transfer with the oldest expected pooled result.
  always @(posedge clk) begin
    pooled_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_pools.size() == 0) begin
        report("unexpected result, row", out_if.out_row, -1);
      end else begin
        want = pending_pools.pop_front();
        if (out_if.max_value !== want.max_value)
          report("max_value", out_if.max_value, want.max_value);
        if (out_if.out_row !== want.out_row) report("out_row", out_if.out_row, want.out_row);
        if (out_if.out_col !== want.out_col) report("out_col", out_if.out_col, want.out_col);
        if (out_if.end_of_plane !== want.end_of_plane)
          report("end_of_plane", out_if.end_of_plane, want.end_of_plane);
      end
    end
  end

  // Reset defaults: a few samples of the 1024-wide plane give no result.
  task automatic test_reset_defaults();
    for (int i = 0; i < 4; i++) send_sample(rand_sample(), i[0]);
  endtask

  // Extreme values, all-padding windows and a plain 2x2 pool.
  task automatic test_directed();
    setup(2, 2, 2, 2, 4, 4);
    send_sample(16'sh8000, 1'b0); send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh1234, 1'b1); send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0); send_sample(16'sh8001, 1'b0);
    send_sample(16'sh0000, 1'b1); send_sample(16'sh7fff, 1'b1);
    send_sample(16'shffff, 1'b0); send_sample(16'sh0100, 1'b1);
    send_sample(16'sh0000, 1'b0); send_sample(16'sh7fff, 1'b0);
    send_sample(16'shff00, 1'b0); send_sample(16'sh5555, 1'b1);
    send_sample(16'sh8000, 1'b0); send_sample(16'shffff, 1'b0);
  endtask

  // Out-of-range registers, including stray high data bits.
  task automatic test_out_of_range();
    setup(0, 15, 0, 15, 5, 0);
    send_plane(5, 20);
    setup(11'h7f3, 11'h7f3, 11'h7f1, 11'h7f2, 0, 3);
    send_plane(3, 20);
    setup(1, 1, 15, 15, 2047, 1);
    send_plane(200, 30);
  endtask

  // A window larger than the plane gives nothing, not even end of plane.
  task automatic test_window_too_big();
    setup(8, 8, 1, 1, 4, 4);
    send_plane(16, 10);
  endtask

  // Unused indexes leave the plane running; a listed write restarts it.
  task automatic test_restart();
    setup(2, 3, 1, 2, 5, 4);
    send_plane(7, 20);
    wait_idle();
    cfg_write(3'd6, 11'h7ff);
    cfg_write(3'd7, 11'h000);
    cfg_if.valid <= 1'b0;
    send_plane(9, 20);
    wait_idle();
    cfg_write(REG_STRIDE_COLS, 11'd1);
    cfg_if.valid <= 1'b0;
    send_plane(20, 20);
  endtask

  // Narrow plane with the tallest kernel, stride 8 and height above its range.
  task automatic test_tall_plane();
    setup(8, 1, 8, 8, 1, 2047);
    send_plane(64, 25);
  endtask

  // Random settings with whole planes, some cut short by a restart.
  task automatic test_random();
    int kh, kw, pw, ph, n;
    while (sent_items < RAND_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      kh = $urandom_range(1, 4);
      kw = $urandom_range(1, 4);
      if ($urandom_range(0, 5) == 0) kh = 8;
      pw = $urandom_range(kw, kw + 12);
      ph = $urandom_range(kh, kh + 6);
      setup(kh, kw, $urandom_range(0, 5) == 0 ? 15 : $urandom_range(1, 4),
            $urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 4), pw, ph);
      n = pw * ph * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, pw * ph);
      send_plane(n, $urandom_range(0, 4) == 0 ? 90 : 20);
    end
    no_gaps = 0;
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    in_if.is_pad <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= '0;
    mismatches  = 0;
    cycle_count = 0;
    sent_items  = 0;
    no_gaps     = 0;
    win_h = 2; win_w = 2; step_c = 2; step_r = 2;
    span_w = 1024; span_h = 1024;
    cur_row = 0; cur_col = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed();
    test_out_of_range();
    test_window_too_big();
    test_restart();
    test_tall_plane();
    test_random();
    wait_idle();

    if (mismatches == 0) begin
      $display("** max_pool_2d_stream_top: PASSED **");
    end else begin
      $display("** max_pool_2d_stream_top: FAILED **");
    end
    $finish;
  end

endmodule
